### sv/protobuf_wire_field_decoder_unit_defines.svh
// -----------------------------------------------------------------------------
// protobuf_wire_field_decoder_unit_defines
// Assertion macros shared by the checker of the wire field decoder.
// -----------------------------------------------------------------------------
`ifndef PROTOBUF_WIRE_FIELD_DECODER_UNIT_DEFINES_SVH
`define PROTOBUF_WIRE_FIELD_DECODER_UNIT_DEFINES_SVH

// check a property outside of reset
`define PWFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property on the cycle after reset is asserted
`define PWFD_ASSERT_AFTER_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

### sv/pwfd_pkg.sv
// -----------------------------------------------------------------------------
// pwfd_pkg
// Types and constants of the protobuf wire field decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwfd_pkg;

    localparam logic [23:0] MAX_MESSAGE_BYTES = 24'd65535;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_TUSER_W = 5;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_SCALAR  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_EMPTY   = 2'd3;

    localparam logic [2:0] WT_VARINT    = 3'd0;
    localparam logic [2:0] WT_FIXED64   = 3'd1;
    localparam logic [2:0] WT_DELIMITED = 3'd2;
    localparam logic [2:0] WT_FIXED32   = 3'd5;

    localparam logic [3:0] VARINT_LAST_INDEX = 4'd9;
    localparam logic [3:0] FIXED64_BYTES     = 4'd8;
    localparam logic [3:0] FIXED32_BYTES     = 4'd4;

    typedef enum logic [4:0] {
        PH_TAG     = 5'b00001,
        PH_VARINT  = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_FIXED   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_message;
        logic [15:0] message_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] tag_field;
        logic [2:0]  tag_type;
        logic [63:0] scalar_value;
        logic [7:0]  payload_byte;
        logic        first_of_field;
        logic        last_of_field;
        logic        message_end;
        logic        stopped_early;
    } result_t;

    typedef struct packed {
        logic advance;
        logic load_result;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

### sv/protobuf_wire_field_decoder_unit.sv
// -----------------------------------------------------------------------------
// protobuf_wire_field_decoder_unit
// Pipeline: 2 register stages (input reg, result reg); a result is offered on m_tvalid
// once its byte has passed the input register and been loaded into the result register.
// Throughput: one byte per cycle; the per-byte decode between the two registers sets it.
// A resultless byte still steps the parser; the output register stalls only on m_tready.
// Reset: synchronous, empties both registers; the parser idles until first_of_message.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module protobuf_wire_field_decoder_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // data_byte[7:0], message_length[23:8]
    input  wire logic [23:0]  s_tdata,
    // first_of_message[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tag_field[31:0], tag_type[34:32], scalar_value[98:35],
    // payload_byte[106:99], zero[111:107]
    output logic [111:0]      m_tdata,
    // record_kind[1:0], first_of_field[2], last_of_field[3], stopped_early[4]
    output logic [4:0]        m_tuser,
    // message_end
    output logic              m_tlast
);

    pwfd_pkg::pipe_ctrl_t ctrl;
    pwfd_pkg::in_item_t   item;
    pwfd_pkg::result_t    res;
    pwfd_pkg::result_t    res_out;
    logic                 item_valid;
    logic                 res_valid;

    assign ctrl.advance     = item_valid && (!m_tvalid || m_tready);
    assign ctrl.load_result = ctrl.advance && res_valid;

    pwfd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .ctrl       (ctrl),
        .item_valid (item_valid),
        .item       (item)
    );

    pwfd_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pwfd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_out  (res_out)
    );

    assign m_tdata = {5'd0, res_out.payload_byte, res_out.scalar_value,
                      res_out.tag_type, res_out.tag_field};
    assign m_tuser = {res_out.stopped_early, res_out.last_of_field,
                      res_out.first_of_field, res_out.record_kind};
    assign m_tlast = res_out.message_end;

endmodule

`default_nettype wire

### sv/pwfd_in_reg.sv
// -----------------------------------------------------------------------------
// pwfd_in_reg
// Input register: captures one transaction and holds it until the parser takes it.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwfd_in_reg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pwfd_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic [pwfd_pkg::IN_TUSER_W-1:0] s_tuser,
    input  wire pwfd_pkg::pipe_ctrl_t           ctrl,
    output logic                                item_valid,
    output pwfd_pkg::in_item_t                  item
);

    logic               valid_reg;
    logic               valid_next;
    pwfd_pkg::in_item_t item_reg;
    logic               accept;

    assign s_tready   = !valid_reg || ctrl.advance;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (ctrl.advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.data_byte        <= s_tdata[7:0];
            item_reg.message_length   <= s_tdata[23:8];
            item_reg.first_of_message <= s_tuser[0];
        end
    end

endmodule

`default_nettype wire

### sv/pwfd_step.sv
// -----------------------------------------------------------------------------
// pwfd_step
// Parser state and the per-byte decode of tags, varints, fixed and delimited values.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwfd_step (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire pwfd_pkg::pipe_ctrl_t ctrl,
    input  wire pwfd_pkg::in_item_t  item,
    output logic                     res_valid,
    output pwfd_pkg::result_t        res
);

    pwfd_pkg::phase_t phase_reg, phase_next, r_phase;
    logic [63:0] acc_reg, acc_next, r_acc;
    logic [3:0]  vidx_reg, vidx_next, r_vidx;
    logic [31:0] fn_reg, fn_next, r_fn;
    logic [2:0]  wt_reg, wt_next, r_wt;
    logic [15:0] blm_reg, blm_next, r_blm;
    logic [15:0] blv_reg, blv_next, r_blv;
    logic        halt_reg, halt_next, r_halt;

    logic [15:0] len_sat;
    logic [15:0] blm_dec;
    logic [15:0] blv_dec;
    logic        end_flag;
    logic [5:0]  vshift;
    logic [63:0] vacc;
    logic        vdone;
    logic [3:0]  fix_total;
    logic [3:0]  fix_diff;
    logic [63:0] fix_acc;
    logic [3:0]  fix_need;
    logic        do_halt;

    always_comb begin
        len_sat = ({8'd0, item.message_length} > pwfd_pkg::MAX_MESSAGE_BYTES)
                ? pwfd_pkg::MAX_MESSAGE_BYTES[15:0] : item.message_length;

        r_phase = phase_reg;
        r_acc   = acc_reg;
        r_vidx  = vidx_reg;
        r_fn    = fn_reg;
        r_wt    = wt_reg;
        r_blm   = blm_reg;
        r_blv   = blv_reg;
        r_halt  = halt_reg;
        if (item.first_of_message) begin
            r_phase = pwfd_pkg::PH_TAG;
            r_acc   = '0;
            r_vidx  = '0;
            r_fn    = '0;
            r_wt    = '0;
            r_blm   = len_sat;
            r_blv   = '0;
            r_halt  = 1'b0;
        end

        phase_next = r_phase;
        acc_next   = r_acc;
        vidx_next  = r_vidx;
        fn_next    = r_fn;
        wt_next    = r_wt;
        blm_next   = r_blm;
        blv_next   = r_blv;
        halt_next  = r_halt;
        res_valid  = 1'b0;
        res        = '0;
        do_halt    = 1'b0;

        blm_dec  = r_blm - 16'd1;
        end_flag = (blm_dec == 16'd0);
        blv_dec  = (r_blv != 16'd0) ? (r_blv - 16'd1) : 16'd0;

        vshift = 6'(({3'd0, r_vidx} << 3) - {3'd0, r_vidx});
        vacc   = r_acc | (64'(item.data_byte[6:0]) << vshift);
        vdone  = !item.data_byte[7] || (r_vidx >= pwfd_pkg::VARINT_LAST_INDEX) || end_flag;

        fix_total = (r_wt == pwfd_pkg::WT_FIXED64) ? pwfd_pkg::FIXED64_BYTES
                                                   : pwfd_pkg::FIXED32_BYTES;
        fix_diff  = fix_total - r_blv[3:0];
        fix_acc   = r_acc | (64'(item.data_byte) << {fix_diff[2:0], 3'b000});
        fix_need  = (vacc[2:0] == pwfd_pkg::WT_FIXED64) ? pwfd_pkg::FIXED64_BYTES
                                                        : pwfd_pkg::FIXED32_BYTES;

        if (r_blm != 16'd0) begin
            blm_next        = blm_dec;
            res.message_end = end_flag;
            if (r_halt) begin
                if (end_flag) begin
                    res_valid         = 1'b1;
                    res.record_kind   = pwfd_pkg::KIND_NONE;
                    res.stopped_early = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    pwfd_pkg::PH_VARINT: begin
                        acc_next  = vacc;
                        vidx_next = vdone ? 4'd0 : (r_vidx + 4'd1);
                        if (vdone) begin
                            res_valid        = 1'b1;
                            res.record_kind  = pwfd_pkg::KIND_SCALAR;
                            res.scalar_value = vacc;
                            acc_next         = '0;
                            phase_next       = pwfd_pkg::PH_TAG;
                        end
                    end
                    pwfd_pkg::PH_LENGTH: begin
                        acc_next  = vacc;
                        vidx_next = vdone ? 4'd0 : (r_vidx + 4'd1);
                        if (vdone) begin
                            if (vacc == 64'd0) begin
                                phase_next      = pwfd_pkg::PH_TAG;
                                res_valid       = 1'b1;
                                res.record_kind = pwfd_pkg::KIND_EMPTY;
                            end else if (vacc > {48'd0, blm_dec}) begin
                                do_halt = 1'b1;
                            end else begin
                                blv_next   = vacc[15:0];
                                phase_next = pwfd_pkg::PH_PAYLOAD;
                                if (end_flag) begin
                                    res_valid       = 1'b1;
                                    res.record_kind = pwfd_pkg::KIND_NONE;
                                end
                            end
                        end
                    end
                    pwfd_pkg::PH_PAYLOAD: begin
                        blv_next           = blv_dec;
                        res_valid          = 1'b1;
                        res.record_kind    = pwfd_pkg::KIND_PAYLOAD;
                        res.payload_byte   = item.data_byte;
                        res.first_of_field = ({48'd0, r_blv} == r_acc);
                        res.last_of_field  = (blv_dec == 16'd0);
                        if (blv_dec == 16'd0) begin
                            phase_next = pwfd_pkg::PH_TAG;
                            acc_next   = '0;
                        end
                    end
                    pwfd_pkg::PH_FIXED: begin
                        acc_next = fix_acc;
                        blv_next = blv_dec;
                        if (blv_dec == 16'd0) begin
                            res_valid        = 1'b1;
                            res.record_kind  = pwfd_pkg::KIND_SCALAR;
                            res.scalar_value = fix_acc;
                            acc_next         = '0;
                            phase_next       = pwfd_pkg::PH_TAG;
                        end
                    end
                    default: begin
                        acc_next  = vacc;
                        vidx_next = vdone ? 4'd0 : (r_vidx + 4'd1);
                        if (vdone) begin
                            fn_next  = vacc[34:3];
                            wt_next  = vacc[2:0];
                            acc_next = '0;
                            unique case (vacc[2:0]) inside
                                pwfd_pkg::WT_VARINT: begin
                                    if (end_flag) begin
                                        res_valid       = 1'b1;
                                        res.record_kind = pwfd_pkg::KIND_SCALAR;
                                    end else begin
                                        phase_next = pwfd_pkg::PH_VARINT;
                                    end
                                end
                                pwfd_pkg::WT_DELIMITED: begin
                                    if (end_flag) begin
                                        res_valid       = 1'b1;
                                        res.record_kind = pwfd_pkg::KIND_EMPTY;
                                    end else begin
                                        phase_next = pwfd_pkg::PH_LENGTH;
                                    end
                                end
                                pwfd_pkg::WT_FIXED64, pwfd_pkg::WT_FIXED32: begin
                                    if (blm_dec < {12'd0, fix_need}) begin
                                        do_halt = 1'b1;
                                    end else begin
                                        blv_next   = {12'd0, fix_need};
                                        phase_next = pwfd_pkg::PH_FIXED;
                                    end
                                end
                                default: begin
                                    do_halt = 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
                if (do_halt) begin
                    halt_next         = 1'b1;
                    phase_next        = pwfd_pkg::PH_TAG;
                    acc_next          = '0;
                    res_valid         = 1'b1;
                    res.record_kind   = pwfd_pkg::KIND_NONE;
                    res.stopped_early = 1'b1;
                end
            end
        end
        res.tag_field = fn_next;
        res.tag_type  = wt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pwfd_pkg::PH_TAG;
            acc_reg   <= '0;
            vidx_reg  <= '0;
            fn_reg    <= '0;
            wt_reg    <= '0;
            blm_reg   <= '0;
            blv_reg   <= '0;
            halt_reg  <= 1'b0;
        end else if (ctrl.advance) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            vidx_reg  <= vidx_next;
            fn_reg    <= fn_next;
            wt_reg    <= wt_next;
            blm_reg   <= blm_next;
            blv_reg   <= blv_next;
            halt_reg  <= halt_next;
        end
    end

endmodule

`default_nettype wire

### sv/pwfd_out_reg.sv
// -----------------------------------------------------------------------------
// pwfd_out_reg
// Result register: holds one result transaction until the master side takes it.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwfd_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pwfd_pkg::pipe_ctrl_t ctrl,
    input  wire pwfd_pkg::result_t    res,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output pwfd_pkg::result_t         res_out
);

    logic              valid_reg;
    logic              valid_next;
    pwfd_pkg::result_t res_reg;

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.load_result) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_result) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

### sv/pwfd_checker.sv
// -----------------------------------------------------------------------------
// pwfd_checker
// Port-level checks of the wire field decoder, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "protobuf_wire_field_decoder_unit_defines.svh"

module pwfd_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [23:0]  s_tdata,
    input wire logic [0:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata,
    input wire logic [4:0]   m_tuser,
    input wire logic         m_tlast
);

    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata) ^ s_tuser[0];

    `PWFD_ASSERT_AFTER_RST(a_reset_empty, aclk, aresetn, !m_tvalid, "result valid after reset")

    `PWFD_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    `PWFD_ASSERT(a_ready_when_free, aclk, aresetn, (!m_tvalid || m_tready) |-> s_tready, "input stalled while output free")

    `PWFD_ASSERT(a_kind_fields, aclk, aresetn, m_tvalid && (m_tuser[1:0] != pwfd_pkg::KIND_PAYLOAD) |-> !m_tuser[2] && !m_tuser[3] && (m_tdata[106:99] == 8'd0), "payload marks on non-payload record")

endmodule

bind protobuf_wire_field_decoder_unit pwfd_checker u_pwfd_checker (.*);

`default_nettype wire

### tb/protobuf_wire_field_decoder_unit_test.sv
// -----------------------------------------------------------------------------
// protobuf_wire_field_decoder_unit_test
// Self-checking bench for the protobuf wire field decoder. Message bytes go in
// as stream transactions: a few hand-built messages first, then random
// messages. Most random messages are well formed; the rest are truncated,
// abandoned by a restart, pure noise, or zero-length restarts. A scoreboard
// decodes each accepted byte on its own copy of the parser state and compares
// every result transaction field by field, in order. Sender gaps and receiver
// stalls vary by phase. One long receiver hold-off backs the block up.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

class pwfd_scoreboard;
    pwfd_pkg::phase_t  phase;
    logic [63:0]       acc;
    logic [3:0]        vidx;
    logic [31:0]       held_fn;
    logic [2:0]        held_wt;
    logic [15:0]       msg_left;
    logic [15:0]       val_left;
    bit                halted;
    pwfd_pkg::result_t expected_q[$];
    int                errors;

    function new();
        clear_parser();
        errors = 0;
    endfunction

    function void clear_parser();
        phase    = pwfd_pkg::PH_TAG;
        acc      = '0;
        vidx     = '0;
        held_fn  = '0;
        held_wt  = '0;
        msg_left = '0;
        val_left = '0;
        halted   = 1'b0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // fold one base-128 byte into the accumulator; 1 when the varint is closed
    function bit varint_done(logic [7:0] b, bit last_byte);
        if (7 * vidx < 64)
            acc |= {57'd0, b[6:0]} << (7 * vidx);
        if (!b[7] || vidx >= pwfd_pkg::VARINT_LAST_INDEX || last_byte) begin
            vidx = '0;
            return 1'b1;
        end
        vidx++;
        return 1'b0;
    endfunction

    function void push(logic [1:0] kind, logic [63:0] val, logic [7:0] pb, bit f, bit l,
                       bit e, bit stop);
        pwfd_pkg::result_t r;
        r.record_kind    = kind;
        r.tag_field      = held_fn;
        r.tag_type       = held_wt;
        r.scalar_value   = val;
        r.payload_byte   = pb;
        r.first_of_field = f;
        r.last_of_field  = l;
        r.message_end    = e;
        r.stopped_early  = stop;
        expected_q.push_back(r);
    endfunction

    function void stop_decode(bit e);
        halted = 1'b1;
        phase  = pwfd_pkg::PH_TAG;
        acc    = '0;
        push(pwfd_pkg::KIND_NONE, '0, '0, 1'b0, 1'b0, e, 1'b1);
    endfunction

    function void note_input(pwfd_pkg::in_item_t it);
        bit         last_byte;
        bit         f;
        bit         l;
        logic [3:0] total;
        logic [2:0] k;
        if (it.first_of_message) begin
            clear_parser();
            msg_left = it.message_length;
        end
        if (msg_left == 0)
            return;
        msg_left--;
        last_byte = (msg_left == 0);
        if (halted) begin
            if (last_byte)
                push(pwfd_pkg::KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
            return;
        end
        case (phase)
            pwfd_pkg::PH_VARINT: begin
                if (varint_done(it.data_byte, last_byte)) begin
                    push(pwfd_pkg::KIND_SCALAR, acc, '0, 1'b0, 1'b0, last_byte, 1'b0);
                    acc   = '0;
                    phase = pwfd_pkg::PH_TAG;
                end
            end
            pwfd_pkg::PH_LENGTH: begin
                if (varint_done(it.data_byte, last_byte)) begin
                    if (acc == 0) begin
                        phase = pwfd_pkg::PH_TAG;
                        push(pwfd_pkg::KIND_EMPTY, '0, '0, 1'b0, 1'b0, last_byte, 1'b0);
                    end else if (acc > {48'd0, msg_left}) begin
                        stop_decode(last_byte);
                    end else begin
                        val_left = acc[15:0];
                        phase    = pwfd_pkg::PH_PAYLOAD;
                        if (last_byte)
                            push(pwfd_pkg::KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
                    end
                end
            end
            pwfd_pkg::PH_PAYLOAD: begin
                // accumulator still holds the field length here
                f = ({48'd0, val_left} == acc);
                if (val_left > 0)
                    val_left--;
                l = (val_left == 0);
                if (l) begin
                    phase = pwfd_pkg::PH_TAG;
                    acc   = '0;
                end
                push(pwfd_pkg::KIND_PAYLOAD, '0, it.data_byte, f, l, last_byte, 1'b0);
            end
            pwfd_pkg::PH_FIXED: begin
                total = (held_wt == pwfd_pkg::WT_FIXED64) ? pwfd_pkg::FIXED64_BYTES
                                                          : pwfd_pkg::FIXED32_BYTES;
                k     = 3'(total - val_left[3:0]);
                acc  |= {56'd0, it.data_byte} << (8 * k);
                if (val_left > 0)
                    val_left--;
                if (val_left == 0) begin
                    push(pwfd_pkg::KIND_SCALAR, acc, '0, 1'b0, 1'b0, last_byte, 1'b0);
                    acc   = '0;
                    phase = pwfd_pkg::PH_TAG;
                end
            end
            default: begin
                if (varint_done(it.data_byte, last_byte)) begin
                    held_fn = acc[34:3];
                    held_wt = acc[2:0];
                    acc     = '0;
                    case (held_wt) inside
                        pwfd_pkg::WT_VARINT: begin
                            if (last_byte)
                                push(pwfd_pkg::KIND_SCALAR, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
                            else
                                phase = pwfd_pkg::PH_VARINT;
                        end
                        pwfd_pkg::WT_DELIMITED: begin
                            if (last_byte)
                                push(pwfd_pkg::KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
                            else
                                phase = pwfd_pkg::PH_LENGTH;
                        end
                        pwfd_pkg::WT_FIXED64, pwfd_pkg::WT_FIXED32: begin
                            total = (held_wt == pwfd_pkg::WT_FIXED64) ? pwfd_pkg::FIXED64_BYTES
                                                                      : pwfd_pkg::FIXED32_BYTES;
                            if (msg_left < {12'd0, total}) begin
                                stop_decode(last_byte);
                            end else begin
                                val_left = {12'd0, total};
                                phase    = pwfd_pkg::PH_FIXED;
                            end
                        end
                        default: stop_decode(last_byte);
                    endcase
                end
            end
        endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(pwfd_pkg::result_t got);
        pwfd_pkg::result_t want;
        if (expected_q.size() == 0) begin
            $error("result transaction with nothing expected: %h", got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        check_field("record_kind", want.record_kind, got.record_kind);
        check_field("tag_field", want.tag_field, got.tag_field);
        check_field("tag_type", want.tag_type, got.tag_type);
        check_field("scalar_value", want.scalar_value, got.scalar_value);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("first_of_field", want.first_of_field, got.first_of_field);
        check_field("last_of_field", want.last_of_field, got.last_of_field);
        check_field("message_end", want.message_end, got.message_end);
        check_field("stopped_early", want.stopped_early, got.stopped_early);
    endfunction
endclass

module protobuf_wire_field_decoder_unit_test;

    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 400;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [23:0]   s_tdata  = '0;
    logic [0:0]    s_tuser  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [111:0]  m_tdata;
    logic [4:0]    m_tuser;
    logic          m_tlast;

    pwfd_scoreboard sb = new();

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 hold_requests  = 0;
    int                 hold_served    = 0;
    int                 hold_left      = 0;
    int                 in_message_items = 0;
    int                 phase_goal;
    int                 mode;
    int                 send_pcts[4]   = '{0, 79, 0, 11};
    int                 recv_pcts[4]   = '{0, 0, 79, 11};
    logic [7:0]         msg_bytes[$];
    pwfd_pkg::result_t  dut_result;
    pwfd_pkg::in_item_t dut_item;

    protobuf_wire_field_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    assign dut_result.record_kind    = m_tuser[1:0];
    assign dut_result.tag_field      = m_tdata[31:0];
    assign dut_result.tag_type       = m_tdata[34:32];
    assign dut_result.scalar_value   = m_tdata[98:35];
    assign dut_result.payload_byte   = m_tdata[106:99];
    assign dut_result.first_of_field = m_tuser[2];
    assign dut_result.last_of_field  = m_tuser[3];
    assign dut_result.message_end    = m_tlast;
    assign dut_result.stopped_early  = m_tuser[4];

    assign dut_item.data_byte        = s_tdata[7:0];
    assign dut_item.message_length   = s_tdata[23:8];
    assign dut_item.first_of_message = s_tuser[0];

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(dut_result);
            if (s_tvalid && s_tready)
                sb.note_input(dut_item);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // base-128 encode, padded to at least nbytes; a tenth byte closes it
    function automatic void put_varint(logic [63:0] v, int nbytes);
        bit more;
        int i = 0;
        do begin
            more = ((v >> 7) != 0) || (i < nbytes - 1);
            if (i == 9)
                more = 1'($urandom_range(1));
            msg_bytes.push_back({more, v[6:0]});
            v = v >> 7;
            i++;
        end while (more && i < 10);
    endfunction

    function automatic int pad_len();
        return ($urandom_range(9) == 0) ? $urandom_range(1, 10) : 1;
    endfunction

    function automatic void put_field();
        int          sel;
        int          n;
        logic [2:0]  wt;
        logic [63:0] tag;
        logic [63:0] v;
        sel = $urandom_range(99);
        if (sel < 30)
            wt = pwfd_pkg::WT_VARINT;
        else if (sel < 45)
            wt = pwfd_pkg::WT_FIXED64;
        else if (sel < 80)
            wt = pwfd_pkg::WT_DELIMITED;
        else if (sel < 94)
            wt = pwfd_pkg::WT_FIXED32;
        else begin
            do
                wt = 3'($urandom_range(7));
            while (wt == pwfd_pkg::WT_VARINT || wt == pwfd_pkg::WT_FIXED64 ||
                   wt == pwfd_pkg::WT_DELIMITED || wt == pwfd_pkg::WT_FIXED32);
        end
        case ($urandom_range(3))
            0: tag = {29'd0, 32'($urandom_range(1, 15)), wt};
            1: tag = {29'd0, 32'($urandom_range(1, 2047)), wt};
            2: tag = {29'd0, 32'($urandom), wt};
            default: tag = {32'($urandom), 29'($urandom), wt};
        endcase
        put_varint(tag, pad_len());
        case (wt)
            pwfd_pkg::WT_VARINT: begin
                v = {32'($urandom), 32'($urandom)} >> $urandom_range(63);
                put_varint(v, pad_len());
            end
            pwfd_pkg::WT_FIXED64: repeat (pwfd_pkg::FIXED64_BYTES) msg_bytes.push_back(rand_byte());
            pwfd_pkg::WT_FIXED32: repeat (pwfd_pkg::FIXED32_BYTES) msg_bytes.push_back(rand_byte());
            pwfd_pkg::WT_DELIMITED: begin
                n = ($urandom_range(9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
                // now and then claim more content than follows
                if ($urandom_range(19) == 0)
                    put_varint(64'(n + $urandom_range(1, 300)), pad_len());
                else
                    put_varint(64'(n), pad_len());
                repeat (n) msg_bytes.push_back(rand_byte());
            end
            default: repeat ($urandom_range(2)) msg_bytes.push_back(rand_byte());
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= first;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic send_message(input logic [15:0] len, input int n_send);
        for (int i = 0; i < n_send; i++) begin
            send_byte(msg_bytes[i], i == 0, (i == 0) ? len : 16'($urandom));
            if (i < len)
                in_message_items++;
        end
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // varint 150
        msg_bytes = '{8'h08, 8'h96, 8'h01};
        send_message(16'd3, 3);
        // fixed32 with extreme bytes
        msg_bytes = '{8'h15, 8'hFF, 8'h00, 8'h80, 8'h7F};
        send_message(16'd5, 5);
        // delimited, two payload bytes
        msg_bytes = '{8'h1A, 8'h02, 8'h00, 8'hFF};
        send_message(16'd4, 4);
        // empty delimited
        msg_bytes = '{8'h22, 8'h00};
        send_message(16'd2, 2);
        // stray byte outside any message, then zero-length restart
        send_byte(8'h5A, 1'b0, 16'hFFFF);
        send_byte(8'hA5, 1'b1, 16'd0);
        // unknown wire type, later bytes swallowed
        msg_bytes = '{8'h0B, 8'h55, 8'hAA};
        send_message(16'd3, 3);
        // fixed64 tag with no room left
        msg_bytes = '{8'h09};
        send_message(16'd1, 1);
        // partial tag at the message end
        msg_bytes = '{8'h80};
        send_message(16'd1, 1);
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            if (ph == 0)
                hold_requests++;
            phase_goal = in_message_items + PHASE_ITEMS;
            while (in_message_items < phase_goal) begin
                msg_bytes.delete();
                repeat ($urandom_range(1, 4)) put_field();
                mode = $urandom_range(99);
                if (mode < 72) begin
                    send_message(16'(msg_bytes.size()), msg_bytes.size());
                end else if (mode < 82) begin
                    // truncated: trailing bytes fall outside the message
                    send_message(16'($urandom_range(1, msg_bytes.size())), msg_bytes.size());
                end else if (mode < 88) begin
                    // abandoned by the next restart
                    send_message(16'($urandom_range(msg_bytes.size() + 1, 65535)),
                                 $urandom_range(1, msg_bytes.size()));
                end else if (mode < 95) begin
                    msg_bytes.delete();
                    repeat ($urandom_range(1, 12)) msg_bytes.push_back(rand_byte());
                    send_message(16'(msg_bytes.size()), msg_bytes.size());
                end else begin
                    send_byte(rand_byte(), 1'b1, 16'd0);
                    send_byte(rand_byte(), 1'b0, 16'($urandom));
                end
            end
            wait_drain();
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
